>>> design/gpv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state codes of the grid patch vertex generator.
// Depends on nothing; every other file of the block imports it.
package gpv_pkg;

   localparam int MAX_CELLS_DEF  = 256;
   localparam int INDEX_BITS_DEF = 24;
   localparam int ONE_Q16        = 65536;
   localparam int FADE_START_Q16 = 56361;   // 0.86 in Q16
   localparam int SMOOTH_K       = 196608;  // 3.0 in Q16

   localparam int QUOT_W = 17;
   localparam int DIVD_W = 24;
   localparam int DIVN_W = DIVD_W + QUOT_W;

   localparam int POS_W   = 24;
   localparam int CNT_W   = 9;
   localparam int COORD_W = 17;
   localparam int LEVEL_W = 4;
   localparam int EXT_W   = 23;
   localparam int IDX_W   = 24;
   localparam int CSR_W   = 24;
   localparam int CSR_A_W = 3;
   localparam int Q_DEPTH = 2;

   // Corner pick per vertex, bit k for vertex k
   localparam logic [5:0] PICK_U = 6'b010110;
   localparam logic [5:0] PICK_V = 6'b110100;

   typedef enum logic [CSR_A_W-1:0] {
      REG_MIN_X, REG_MAX_X, REG_MIN_Z, REG_MAX_Z,
      REG_COLUMNS, REG_ROWS, REG_LEVEL, REG_OUTER
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] min_x;
      logic signed [POS_W-1:0] max_x;
      logic signed [POS_W-1:0] min_z;
      logic signed [POS_W-1:0] max_z;
      logic [CNT_W-1:0]        columns;
      logic [CNT_W-1:0]        rows;
      logic [LEVEL_W-1:0]      level;
      logic [EXT_W-1:0]        outer;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] u0;
      logic [COORD_W-1:0] u1;
      logic [COORD_W-1:0] v0;
      logic [COORD_W-1:0] v1;
      logic               new_mesh;
   } cell_type;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] dividend;
      logic [DIVD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

   typedef enum logic [1:0] {F_IDLE, F_START, F_WAIT, F_PUSH} front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_MUL, B_POS, B_DIV, B_SQ, B_CUBE, B_OUT
   } back_state_type;

endpackage

>>> design/gpv_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the grid patch vertex generator.
// Depends on gpv_pkg for field widths.
interface gpv_req_if;
   import gpv_pkg::*;
   logic valid;
   logic ready;
   logic [7:0] cell_col;
   logic [7:0] cell_row;
   logic       new_mesh;
   modport source (output valid, cell_col, cell_row, new_mesh, input ready);
   modport sink   (input valid, cell_col, cell_row, new_mesh, output ready);
endinterface

interface gpv_rsp_if;
   import gpv_pkg::*;
   logic valid;
   logic ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_z;
   logic [COORD_W-1:0]      coord_u;
   logic [COORD_W-1:0]      coord_v;
   logic [LEVEL_W-1:0]      vertex_level;
   logic [COORD_W-1:0]      fade;
   logic [IDX_W-1:0]        vertex_index;
   logic                    last_of_cell;
   modport source (output valid, pos_x, pos_z, coord_u, coord_v, vertex_level, fade,
                   vertex_index, last_of_cell, input ready);
   modport sink   (input valid, pos_x, pos_z, coord_u, coord_v, vertex_level, fade,
                   vertex_index, last_of_cell, output ready);
endinterface

>>> design/gpv_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Depends on gpv_pkg; the caller guarantees the quotient fits in 17 bits.
module gpv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gpv_pkg::div_req_type req,
   output gpv_pkg::div_rsp_type rsp
);
   import gpv_pkg::*;

   logic              busy_ff, done_ff;
   logic [4:0]        cnt_ff;
   logic [DIVD_W-1:0] rem_ff, rem_in, div_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [DIVD_W:0]   trial;
   logic              ge;

   assign trial  = {rem_ff, q_ff[QUOT_W-1]};
   assign ge     = trial >= {1'b0, div_ff};
   assign rem_in = ge ? DIVD_W'(trial - {1'b0, div_ff}) : DIVD_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.dividend[DIVN_W-1:QUOT_W];
         q_ff   <= req.dividend[QUOT_W-1:0];
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[QUOT_W-2:0], ge};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule

>>> design/gpv_queue.sv
`timescale 1ns / 1ps
// Two-entry cell queue between the front and back halves.
// Depends on gpv_pkg for the cell record.
module gpv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              pop,
   input  gpv_pkg::cell_type wr_data,
   output gpv_pkg::cell_type rd_data,
   output logic              full,
   output logic              empty
);
   import gpv_pkg::*;

   cell_type   mem_ff [Q_DEPTH];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_data;
   end

   assign rd_data = mem_ff[rptr_ff];
   assign full    = count_ff == 2'(Q_DEPTH);
   assign empty   = count_ff == 2'd0;

endmodule

>>> design/gpv_front.sv
`timescale 1ns / 1ps
// Front half: accepts a cell, clamps it and divides out its four patch coordinates.
// Depends on gpv_pkg, gpv_if and gpv_div.
module gpv_front #(
   parameter int MAX_CELLS = gpv_pkg::MAX_CELLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   gpv_req_if.sink                req_chan,
   input  gpv_pkg::cfg_type       cfg,
   input  logic                   q_full,
   output logic                   q_push,
   output gpv_pkg::cell_type      q_data
);
   import gpv_pkg::*;

   front_state_type  state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [CNT_W-1:0] col_ff, row_ff, nc_ff, nr_ff, nc, nr, col_c, row_c;
   cell_type         cell_ff;
   div_req_type      dreq;
   div_rsp_type      drsp;
   logic [CNT_W-1:0] num, den;
   logic             accept;

   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n == '0) r = CNT_W'(1);
      else if (32'(n) > MAX_CELLS) r = CNT_W'(MAX_CELLS);
      return r;
   endfunction

   assign nc     = sat_count(cfg.columns);
   assign nr     = sat_count(cfg.rows);
   assign col_c  = ({1'b0, req_chan.cell_col} >= nc) ? nc - CNT_W'(1) : {1'b0, req_chan.cell_col};
   assign row_c  = ({1'b0, req_chan.cell_row} >= nr) ? nr - CNT_W'(1) : {1'b0, req_chan.cell_row};
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      unique case (op_ff)
         2'd0:    begin num = col_ff;             den = nc_ff; end
         2'd1:    begin num = col_ff + CNT_W'(1); den = nc_ff; end
         2'd2:    begin num = row_ff;             den = nr_ff; end
         default: begin num = row_ff + CNT_W'(1); den = nr_ff; end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      req_chan.ready   = 1'b0;
      q_push           = 1'b0;
      dreq.start       = 1'b0;
      dreq.dividend    = DIVN_W'({num, 16'b0}) + DIVN_W'(den >> 1);
      dreq.divisor     = DIVD_W'(den);
      unique case (state_ff)
         F_IDLE: begin
            req_chan.ready = 1'b1;
            op_in          = 2'd0;
            if (req_chan.valid) state_in = F_START;
         end
         F_START: begin
            dreq.start = 1'b1;
            state_in   = F_WAIT;
         end
         F_WAIT: begin
            if (drsp.done) begin
               op_in    = op_ff + 2'd1;
               state_in = (op_ff == 2'd3) ? F_PUSH : F_START;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff           <= col_c;
         row_ff           <= row_c;
         nc_ff            <= nc;
         nr_ff            <= nr;
         cell_ff.new_mesh <= req_chan.new_mesh;
      end
      if (state_ff == F_WAIT && drsp.done) begin
         unique case (op_ff)
            2'd0:    cell_ff.u0 <= drsp.quotient;
            2'd1:    cell_ff.u1 <= drsp.quotient;
            2'd2:    cell_ff.v0 <= drsp.quotient;
            default: cell_ff.v1 <= drsp.quotient;
         endcase
      end
   end

   assign q_data = cell_ff;

   gpv_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

endmodule

>>> design/gpv_back.sv
`timescale 1ns / 1ps
// Back half: walks the six vertices of a queued cell, interpolates position,
// computes the edge fade and drives the response register. Depends on gpv_pkg,
// gpv_if and gpv_div.
module gpv_back #(
   parameter int INDEX_BITS = gpv_pkg::INDEX_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   gpv_rsp_if.source         rsp_chan,
   input  gpv_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  gpv_pkg::cell_type q_data,
   output logic              q_pop
);
   import gpv_pkg::*;

   back_state_type state_ff, state_in;
   logic [2:0]     k_ff, k_in;
   logic [INDEX_BITS-1:0] cnt_ff, cnt_in;
   logic           ov_ff, ov_in;
   logic           load_out;

   cell_type       cell_ff;
   logic [COORD_W-1:0] u_sel, v_sel;
   logic signed [POS_W:0]   dx, dz;
   logic signed [42:0]      px_ff, pz_ff, rx, rz;
   logic signed [POS_W+2:0] xs, zs;
   logic signed [POS_W-1:0] x_in, z_in, x_ff, z_ff;
   logic [POS_W-1:0]   ax, az, r, diff;
   logic [EXT_W-1:0]   start_ff, span;
   logic [38:0]        start_prod;
   logic [QUOT_W-1:0]  t_ff;
   logic [2*QUOT_W-1:0] tt_ff;
   logic [QUOT_W:0]    w_ff;
   logic [3*QUOT_W:0]  cube;
   logic [COORD_W-1:0] s_ff;
   logic               s_set;
   logic [COORD_W-1:0] s_val;
   logic               t_set, div_set;
   logic [QUOT_W-1:0]  t_val;
   div_req_type        dreq;
   div_rsp_type        drsp;

   // Fade start follows the outer extent register
   assign start_prod = 39'(cfg.outer) * 39'(FADE_START_Q16) + 39'd32768;
   always_ff @(posedge clock) start_ff <= start_prod[38:16];
   assign span = cfg.outer - start_ff;

   assign u_sel = PICK_U[k_ff] ? cell_ff.u1 : cell_ff.u0;
   assign v_sel = PICK_V[k_ff] ? cell_ff.v1 : cell_ff.v0;
   assign dx    = {cfg.max_x[POS_W-1], cfg.max_x} - {cfg.min_x[POS_W-1], cfg.min_x};
   assign dz    = {cfg.max_z[POS_W-1], cfg.max_z} - {cfg.min_z[POS_W-1], cfg.min_z};

   assign rx   = px_ff + 43'sd32768;
   assign rz   = pz_ff + 43'sd32768;
   assign xs   = $signed({{3{cfg.min_x[POS_W-1]}}, cfg.min_x}) + $signed(rx[42:16]);
   assign zs   = $signed({{3{cfg.min_z[POS_W-1]}}, cfg.min_z}) + $signed(rz[42:16]);
   assign x_in = xs[POS_W-1:0];
   assign z_in = zs[POS_W-1:0];
   assign ax   = x_in[POS_W-1] ? ~x_in + 1'b1 : x_in;
   assign az   = z_in[POS_W-1] ? ~z_in + 1'b1 : z_in;
   assign r    = (ax > az) ? ax : az;
   assign diff = r - {1'b0, start_ff};

   // Classify the radius against the fade band
   always_comb begin
      s_set   = 1'b0;
      s_val   = '0;
      t_set   = 1'b0;
      t_val   = '0;
      div_set = 1'b0;
      priority if (start_ff == cfg.outer) begin
         s_set = 1'b1;
         s_val = (r < {1'b0, start_ff}) ? '0 : COORD_W'(ONE_Q16);
      end else if (r <= {1'b0, start_ff}) begin
         t_set = 1'b1;
      end else if (r >= {1'b0, cfg.outer}) begin
         t_set = 1'b1;
         t_val = QUOT_W'(ONE_Q16);
      end else begin
         div_set = 1'b1;
      end
   end

   assign dreq.start    = (state_ff == B_POS) && div_set;
   assign dreq.dividend = DIVN_W'({diff, 16'b0}) + DIVN_W'(span >> 1);
   assign dreq.divisor  = DIVD_W'(span);

   assign cube     = tt_ff * w_ff + 52'h0_8000_0000;
   assign load_out = (state_ff == B_OUT) && (!ov_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff;
      q_pop    = 1'b0;
      if (rsp_chan.ready) ov_in = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               k_in     = '0;
               if (q_data.new_mesh) cnt_in = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: state_in = B_POS;
         B_POS: begin
            priority if (s_set) state_in = B_OUT;
            else if (t_set)     state_in = B_SQ;
            else                state_in = B_DIV;
         end
         B_DIV:  if (drsp.done) state_in = B_SQ;
         B_SQ:   state_in = B_CUBE;
         B_CUBE: state_in = B_OUT;
         B_OUT: begin
            if (load_out) begin
               ov_in    = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               k_in     = k_ff + 3'd1;
               state_in = (k_ff == 3'd5) ? B_IDLE : B_MUL;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cell_ff <= q_data;
      if (state_ff == B_MUL) begin
         px_ff <= dx * $signed({1'b0, u_sel});
         pz_ff <= dz * $signed({1'b0, v_sel});
      end
      if (state_ff == B_POS) begin
         x_ff <= x_in;
         z_ff <= z_in;
         if (s_set) s_ff <= s_val;
         if (t_set) t_ff <= t_val;
      end
      if (state_ff == B_DIV && drsp.done) t_ff <= drsp.quotient;
      if (state_ff == B_SQ) begin
         tt_ff <= t_ff * t_ff;
         w_ff  <= (QUOT_W+1)'(SMOOTH_K) - {t_ff, 1'b0};
      end
      if (state_ff == B_CUBE) s_ff <= cube[48:32];
      if (load_out) begin
         rsp_chan.pos_x        <= x_ff;
         rsp_chan.pos_z        <= z_ff;
         rsp_chan.coord_u      <= u_sel;
         rsp_chan.coord_v      <= v_sel;
         rsp_chan.vertex_level <= cfg.level;
         rsp_chan.fade         <= COORD_W'(ONE_Q16) - s_ff;
         rsp_chan.vertex_index <= IDX_W'(cnt_ff);
         rsp_chan.last_of_cell <= (k_ff == 3'd5);
      end
   end

   assign rsp_chan.valid = ov_ff;

   gpv_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

endmodule

>>> design/grid_patch_vertex_generator.sv
`timescale 1ns / 1ps
// Grid patch vertex generator: turns grid cells into six triangle vertices each.
// Depends on gpv_pkg, gpv_if, gpv_front, gpv_queue and gpv_back.
//
// Usage: program the patch through the csr_ port (index 0..7: bounds, column and
// row counts, level, outer extent) while the block is idle. Send cells on
// req_chan; each returns six vertices on rsp_chan, last_of_cell marking the sixth.
// A cell with new_mesh set restarts the vertex index at zero.
// Front: a cell is taken, then four divisions by the front's bit-serial divider
// give its u/v corners; the next cell is taken once this one is in the queue.
// Back: each vertex is multiplied and positioned, divided by the back's divider
// inside the fade band, squared and cubed, then output; the division is skipped
// outside the band, and the square and cube too when the fade edges coincide.
// A two-cell queue lets the front take the next cell while the back works.
// Reset (synchronous, active high) restores register defaults, empties the
// queue and clears the vertex index. When rsp_chan stalls, the held vertex
// stays in the output register and the back waits; the front keeps filling
// the queue until it is full, then req_chan.ready drops.
module grid_patch_vertex_generator #(
   parameter int MAX_CELLS  = gpv_pkg::MAX_CELLS_DEF,
   parameter int INDEX_BITS = gpv_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   gpv_req_if.sink                       req_chan,
   gpv_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [gpv_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [gpv_pkg::CSR_W-1:0]     csr_wdata
);
   import gpv_pkg::*;

   cfg_type       cfg_ff;
   queue_ctl_type qctl;
   cell_type      q_wr, q_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x   <= '0;
         cfg_ff.max_x   <= '0;
         cfg_ff.min_z   <= '0;
         cfg_ff.max_z   <= '0;
         cfg_ff.columns <= CNT_W'(1);
         cfg_ff.rows    <= CNT_W'(1);
         cfg_ff.level   <= '0;
         cfg_ff.outer   <= EXT_W'(ONE_Q16);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_MIN_X:   cfg_ff.min_x   <= csr_wdata;
            REG_MAX_X:   cfg_ff.max_x   <= csr_wdata;
            REG_MIN_Z:   cfg_ff.min_z   <= csr_wdata;
            REG_MAX_Z:   cfg_ff.max_z   <= csr_wdata;
            REG_COLUMNS: cfg_ff.columns <= csr_wdata[CNT_W-1:0];
            REG_ROWS:    cfg_ff.rows    <= csr_wdata[CNT_W-1:0];
            REG_LEVEL:   cfg_ff.level   <= csr_wdata[LEVEL_W-1:0];
            REG_OUTER:   cfg_ff.outer   <= csr_wdata[EXT_W-1:0];
            default:     ;
         endcase
      end
   end

   gpv_front #(.MAX_CELLS(MAX_CELLS)) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .cfg(cfg_ff),
      .q_full(qctl.full), .q_push(qctl.push), .q_data(q_wr)
   );

   gpv_queue u_queue (
      .clock(clock), .reset(reset), .push(qctl.push), .pop(qctl.pop),
      .wr_data(q_wr), .rd_data(q_rd), .full(qctl.full), .empty(qctl.empty)
   );

   gpv_back #(.INDEX_BITS(INDEX_BITS)) u_back (
      .clock(clock), .reset(reset), .rsp_chan(rsp_chan), .cfg(cfg_ff),
      .q_empty(qctl.empty), .q_data(q_rd), .q_pop(qctl.pop)
   );

endmodule

>>> tb/sv/grid_patch_vertex_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the grid patch vertex generator: directed table then random cells,
// each cell checked vertex by vertex against an in-bench prediction of the six triangle vertices.
// Depends on gpv_pkg, gpv_if and the block's RTL.
module grid_patch_vertex_generator_test;
   import gpv_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_z;
      logic [COORD_W-1:0]      coord_u;
      logic [COORD_W-1:0]      coord_v;
      logic [LEVEL_W-1:0]      level;
      logic [COORD_W-1:0]      fade;
      logic [IDX_W-1:0]        index;
      logic                    last;
   } vertex_type;

   typedef struct {
      logic [7:0] col;
      logic [7:0] row;
      logic       new_mesh;
      logic       typed;     // first vertex below is given by hand
      vertex_type first;
   } cell_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_A_W-1:0] csr_index = REG_MIN_X;
   logic [CSR_W-1:0] csr_wdata = '0;

   gpv_req_if req_chan ();
   gpv_rsp_if rsp_chan ();

   grid_patch_vertex_generator dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // shadow of the patch registers and the vertex counter
   longint min_x, max_x, min_z, max_z;
   int unsigned columns_reg, rows_reg, level_reg, outer_reg;
   longint unsigned vertex_tally;

   vertex_type pending_vertices[$];
   vertex_type typed_vertices[$];
   bit typed_flags[$];
   int errors = 0;
   int cycle_count = 0;
   bit quiet = 0;          // no idling near the end
   bit hold_rsp = 0;       // long receiver stall

   function automatic int unsigned clamp_count(int unsigned n);
      if (n < 1) return 1;
      if (n > MAX_CELLS_DEF) return MAX_CELLS_DEF;
      return n;
   endfunction

   function automatic int unsigned coord_fraction(int unsigned c, int unsigned n);
      return (longint'(c) * ONE_Q16 + n / 2) / n;
   endfunction

   function automatic longint interp_position(longint lo, longint hi, int unsigned u);
      longint prod;
      prod = (hi - lo) * longint'(u) + 32768;
      return lo + (prod >>> 16);
   endfunction

   function automatic int unsigned fade_weight(longint x, longint z);
      longint unsigned r, start, span, t, s;
      r = (x < 0 ? -x : x);
      if ((z < 0 ? -z : z) > r) r = (z < 0 ? -z : z);
      start = (longint'(outer_reg) * FADE_START_Q16 + 32768) >> 16;
      if (start == outer_reg) begin
         s = (r < start) ? 0 : ONE_Q16;
      end else begin
         span = outer_reg - start;
         if (r <= start) t = 0;
         else if (r >= outer_reg) t = ONE_Q16;
         else t = (((r - start) << 16) + span / 2) / span;
         s = (t * t * (SMOOTH_K - 2 * t) + (64'd1 << 31)) >> 32;
      end
      return ONE_Q16 - s;
   endfunction

   task automatic predict_cell_vertices(logic [7:0] col_in, logic [7:0] row_in, logic nm);
      int unsigned nc, nr, col, row, u, v;
      int unsigned us[2], vs[2];
      vertex_type vx;
      nc = clamp_count(columns_reg);
      nr = clamp_count(rows_reg);
      col = col_in;
      row = row_in;
      if (nm) vertex_tally = 0;
      if (col >= nc) col = nc - 1;
      if (row >= nr) row = nr - 1;
      us[0] = coord_fraction(col, nc);
      us[1] = coord_fraction(col + 1, nc);
      vs[0] = coord_fraction(row, nr);
      vs[1] = coord_fraction(row + 1, nr);
      for (int k = 0; k < 6; k++) begin
         longint x, z;
         u = us[PICK_U[k]];
         v = vs[PICK_V[k]];
         x = interp_position(min_x, max_x, u);
         z = interp_position(min_z, max_z, v);
         vx.pos_x = x[POS_W-1:0];
         vx.pos_z = z[POS_W-1:0];
         vx.coord_u = COORD_W'(u);
         vx.coord_v = COORD_W'(v);
         vx.level = LEVEL_W'(level_reg);
         vx.fade = COORD_W'(fade_weight(x, z));
         vx.index = vertex_tally[IDX_W-1:0];
         vx.last = (k == 5);
         pending_vertices.insert(pending_vertices.size(), vx);
         vertex_tally = (vertex_tally + 1) & ((64'd1 << INDEX_BITS_DEF) - 1);
      end
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_MIN_X: begin min_x = longint'($signed(value)); end
         REG_MAX_X: begin max_x = longint'($signed(value)); end
         REG_MIN_Z: begin min_z = longint'($signed(value)); end
         REG_MAX_Z: begin max_z = longint'($signed(value)); end
         REG_COLUMNS: begin columns_reg = value[CNT_W-1:0]; end
         REG_ROWS: begin rows_reg = value[CNT_W-1:0]; end
         REG_LEVEL: begin level_reg = value[LEVEL_W-1:0]; end
         REG_OUTER: begin outer_reg = value[EXT_W-1:0]; end
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic write_patch(int bx0, int bx1, int bz0, int bz1, int cols, int rws,
                              int lvl, int outer);
      write_register(REG_MIN_X, CSR_W'(bx0));
      write_register(REG_MAX_X, CSR_W'(bx1));
      write_register(REG_MIN_Z, CSR_W'(bz0));
      write_register(REG_MAX_Z, CSR_W'(bz1));
      write_register(REG_COLUMNS, CSR_W'(cols));
      write_register(REG_ROWS, CSR_W'(rws));
      write_register(REG_LEVEL, CSR_W'(lvl));
      write_register(REG_OUTER, CSR_W'(outer));
   endtask

   // wait for every vertex, then for the back end to settle
   task automatic drain_block();
      wait (pending_vertices.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   int send_gap;
   task automatic send_cell(logic [7:0] col, logic [7:0] row, logic nm);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         send_gap = $urandom_range(1, 11);
         @(posedge clock);
         req_chan.valid <= 0;
         repeat (send_gap - 1) @(posedge clock);
      end
      @(posedge clock);
      req_chan.valid <= 1;
      req_chan.cell_col <= col;
      req_chan.cell_row <= row;
      req_chan.new_mesh <= nm;
      do @(posedge clock); while (!req_chan.ready);
      predict_cell_vertices(col, row, nm);
      req_chan.valid <= 0;
   endtask

   initial begin
      req_chan.valid = 0;
      req_chan.cell_col = 0;
      req_chan.cell_row = 0;
      req_chan.new_mesh = 0;
   end

   // receiver: random stall bursts, or a long hold on request
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_chan.ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= 1;
      end
   end
   initial rsp_chan.ready = 0;

   // vertex checker
   always @(posedge clock) begin
      vertex_type want, got;
      bit typed_chk;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.pos_x = rsp_chan.pos_x;
         got.pos_z = rsp_chan.pos_z;
         got.coord_u = rsp_chan.coord_u;
         got.coord_v = rsp_chan.coord_v;
         got.level = rsp_chan.vertex_level;
         got.fade = rsp_chan.fade;
         got.index = rsp_chan.vertex_index;
         got.last = rsp_chan.last_of_cell;
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex x=%0d z=%0d", $time, got.pos_x, got.pos_z);
            errors++;
         end else begin
            want = pending_vertices.pop_front();
            typed_chk = typed_flags.size() > 0 ? typed_flags.pop_front() : 0;
            if (typed_chk) begin
               vertex_type hand;
               hand = typed_vertices.pop_front();
               if (got !== hand) begin
                  $display("%0t: first vertex exp %h got %h", $time, hand, got);
                  errors++;
               end
            end
            if (got.pos_x !== want.pos_x) begin
               $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, got.pos_x);
               errors++;
            end
            if (got.pos_z !== want.pos_z) begin
               $display("%0t: pos_z exp %0d got %0d", $time, want.pos_z, got.pos_z);
               errors++;
            end
            if (got.coord_u !== want.coord_u) begin
               $display("%0t: coord_u exp %0d got %0d", $time, want.coord_u, got.coord_u);
               errors++;
            end
            if (got.coord_v !== want.coord_v) begin
               $display("%0t: coord_v exp %0d got %0d", $time, want.coord_v, got.coord_v);
               errors++;
            end
            if (got.level !== want.level) begin
               $display("%0t: level exp %0d got %0d", $time, want.level, got.level);
               errors++;
            end
            if (got.fade !== want.fade) begin
               $display("%0t: fade exp %0d got %0d", $time, want.fade, got.fade);
               errors++;
            end
            if (got.index !== want.index) begin
               $display("%0t: index exp %0d got %0d", $time, want.index, got.index);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("grid_patch_vertex_generator_test: FAIL");
         $finish;
      end
   end

   cell_row_type directed[$];

   task automatic add_row(int col, int row, bit nm, bit typed, vertex_type first);
      cell_row_type r;
      r.col = 8'(col);
      r.row = 8'(row);
      r.new_mesh = nm;
      r.typed = typed;
      r.first = first;
      directed.insert(directed.size(), r);
   endtask

   function automatic vertex_type hand_vertex(int x, int z, int u, int v, int lvl, int f,
                                             int idx);
      vertex_type vx;
      vx.pos_x = POS_W'(x);
      vx.pos_z = POS_W'(z);
      vx.coord_u = COORD_W'(u);
      vx.coord_v = COORD_W'(v);
      vx.level = LEVEL_W'(lvl);
      vx.fade = COORD_W'(f);
      vx.index = IDX_W'(idx);
      vx.last = 0;
      return vx;
   endfunction

   task automatic run_directed();
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            typed_flags.insert(typed_flags.size(), 1'b1);
            typed_vertices.insert(typed_vertices.size(), directed[i].first);
            for (int k = 1; k < 6; k++) typed_flags.insert(typed_flags.size(), 1'b0);
         end else begin
            for (int k = 0; k < 6; k++) typed_flags.insert(typed_flags.size(), 1'b0);
         end
         send_cell(directed[i].col, directed[i].row, directed[i].new_mesh);
      end
      directed.delete();
      wait (pending_vertices.size() == 0);
      typed_flags.delete();
   endtask

   task automatic random_cells(int count, int cols, int rws);
      for (int i = 0; i < count; i++) begin
         logic [7:0] c, r;
         // mostly cells inside the patch, some beyond it
         if ($urandom_range(0, 7) == 0) begin
            c = $urandom;
            r = $urandom;
         end else begin
            c = $urandom_range(0, cols - 1);
            r = $urandom_range(0, rws - 1);
         end
         send_cell(c, r, $urandom_range(0, 19) == 0);
      end
   endtask

   task automatic random_patch(output int cols, output int rws);
      int span;
      span = $urandom_range(0, 3) == 0 ? 8388607 : $urandom_range(256, 40000);
      cols = $urandom_range(1, 3) == 1 ? $urandom_range(1, 256) : $urandom_range(1, 12);
      rws = $urandom_range(1, 3) == 1 ? $urandom_range(1, 256) : $urandom_range(1, 12);
      write_patch($urandom_range(0, span) - span / 2, $urandom_range(0, span) - span / 2,
                  $urandom_range(0, span) - span / 2, $urandom_range(0, span) - span / 2,
                  cols, rws, $urandom_range(0, 15), $urandom_range(0, span));
   endtask

   initial begin
      int cols, rws;
      min_x = 0; max_x = 0; min_z = 0; max_z = 0;
      columns_reg = 1; rows_reg = 1; level_reg = 0; outer_reg = 65536;
      vertex_tally = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // after reset: two cells, both on the single cell at the origin, fade full
      add_row(0, 0, 0, 1, hand_vertex(0, 0, 0, 0, 0, ONE_Q16, 0));
      add_row(255, 255, 1, 1, hand_vertex(0, 0, 0, 0, 0, ONE_Q16, 0));
      run_directed();
      drain_block();

      // extreme bounds, full counts, equal fade edges (outer 0)
      write_patch(-8388608, 8388607, -8388608, 8388607, 256, 256, 15, 0);
      add_row(0, 0, 1, 1, hand_vertex(-8388608, -8388608, 0, 0, 15, 0, 0));
      add_row(255, 255, 0, 0, hand_vertex(0, 0, 0, 0, 0, 0, 0));
      add_row(128, 7, 0, 0, hand_vertex(0, 0, 0, 0, 0, 0, 0));
      run_directed();
      drain_block();

      // zero counts saturate to one; oversize counts to the maximum; fade band covered
      write_patch(8388607, -8388608, 1000, -1000, 0, 511, 5, 8388607);
      add_row(0, 200, 1, 0, hand_vertex(0, 0, 0, 0, 0, 0, 0));
      add_row(3, 255, 0, 0, hand_vertex(0, 0, 0, 0, 0, 0, 0));
      run_directed();
      drain_block();
      write_patch(-2000, 2000, -2000, 2000, 7, 5, 9, 1900);
      for (int i = 0; i < 16; i++) add_row(i % 8, i % 6, i == 0, 0, hand_vertex(0, 0, 0, 0, 0, 0, 0));
      run_directed();
      drain_block();

      // receiver held off while cells keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
         random_cells(8, 7, 5);
      join
      drain_block();

      for (int phase = 0; phase < 10; phase++) begin
         random_patch(cols, rws);
         if (phase == 9) quiet = 1;
         random_cells(30, cols, rws);
         drain_block();
      end

      if (errors == 0) begin
         $display("grid_patch_vertex_generator_test: PASS");
      end else begin
         $display("grid_patch_vertex_generator_test: FAIL");
      end
      $finish;
   end
endmodule

>>> filelist.f
design/gpv_pkg.sv
design/gpv_if.sv
design/gpv_div.sv
design/gpv_queue.sv
design/gpv_front.sv
design/gpv_back.sv
design/grid_patch_vertex_generator.sv
tb/sv/grid_patch_vertex_generator_test.sv
